### design/wildcard_nfa_matcher_unit_assert.svh
// ----------------------------------------------------------------------------
// Wildcard NFA matcher assertion macros
// Clocked assertion shorthands on clk, with and without the rst_n guard.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_NFA_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_NFA_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define WNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WNM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WNM_ASSERT(lbl, prop, msg)
`define WNM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### design/wnm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher package
// Shared constants, register indexes and cell interface structs.
// ----------------------------------------------------------------------------
package wnm_pkg;

  // pattern geometry
  localparam int PATTERN_MAX   = 32;
  localparam int PATTERN_WORDS = 4;
  localparam int BYTES_PER_WORD = 8;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 64;
  localparam int LEN_W         = 6;
  localparam int LIVE_W        = PATTERN_MAX + 1;
  localparam int WORD_SEL_W    = 2;

  // wildcard codes
  localparam logic [BYTE_W-1:0] STAR_CODE  = 8'h2A;
  localparam logic [BYTE_W-1:0] QUEST_CODE = 8'h3F;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_LAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd4;

  // per-cell control from the top level
  typedef struct packed {
    logic home;      // position zero, live after reset
    logic first;     // restart at the seed vector
    logic active;    // position below the pattern length
    logic in_range;  // position at or below the pattern length
    logic load;      // item accepted, take the next live bit
    logic wr_en;     // pattern byte write
  } cell_ctl_t;

  // per-cell status to the top level
  typedef struct packed {
    logic stay;  // live star keeps its own position
    logic adv;   // live position hands off to the next cell
    logic star;  // active star, feeds the star fill
    logic live;  // stored live bit
  } cell_out_t;

  // one result item
  typedef struct packed {
    logic matched;
    logic no_live_position;
  } result_t;

endpackage

### design/wnm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher cell
// One pattern position: its pattern byte, its live bit, and the byte compare
// that hands the live token on to the next position.
// ----------------------------------------------------------------------------
module wnm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wnm_pkg::cell_ctl_t          ctl,
  input  logic                        seed_bit,
  input  logic [wnm_pkg::BYTE_W-1:0]  text_byte,
  input  logic [wnm_pkg::BYTE_W-1:0]  wr_byte,
  input  logic                        live_nxt,
  output wnm_pkg::cell_out_t          cell_o
);

  logic [wnm_pkg::BYTE_W-1:0] pat_r;
  logic                       live_r;
  logic                       is_star;
  logic                       is_quest;
  logic                       cur;

  // pattern byte store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
    end else if (ctl.wr_en) begin
      pat_r <= wr_byte;
    end
  end

  // live bit, updated on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= ctl.home;
    end else if (ctl.load) begin
      live_r <= live_nxt;
    end
  end

  assign is_star  = (pat_r == wnm_pkg::STAR_CODE);
  assign is_quest = (pat_r == wnm_pkg::QUEST_CODE);

  // live before this byte: seed on restart, else stored bit within length
  assign cur = ctl.first ? seed_bit : (live_r & ctl.in_range);

  always_comb begin
    cell_o.stay = cur & ctl.active & is_star;
    cell_o.adv  = cur & ctl.active & ~is_star & (is_quest | (pat_r == text_byte));
    cell_o.star = ctl.active & is_star;
    cell_o.live = live_r;
  end

endmodule

### design/wnm_fill.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher star fill
// Spreads live bits forward through runs of stars with one carry chain, and
// builds the restart vector (the leading star run from position zero plus the next position).
// ----------------------------------------------------------------------------
module wnm_fill (
  input  logic [wnm_pkg::LIVE_W-1:0] raw,
  input  logic [wnm_pkg::LIVE_W-1:0] star,
  output logic [wnm_pkg::LIVE_W-1:0] closed,
  output logic [wnm_pkg::LIVE_W-1:0] seed
);

  logic [wnm_pkg::LIVE_W-1:0] run_sum;
  logic [wnm_pkg::LIVE_W-1:0] lead_sum;

  // a live star starts a carry that runs through the star run and lands on
  // the first non-star position; the flipped bits are the reached positions
  assign run_sum = (raw & star) + star;
  assign closed  = raw | (run_sum ^ star);

  // leading run of stars from position zero, plus the position after it
  assign lead_sum = star + wnm_pkg::LIVE_W'(1);
  assign seed     = lead_sum ^ star;

endmodule

### design/wnm_skid.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher result buffer
// Output register with a skid entry, so an item is taken while a result
// waits; stall back to the input comes from a register only.
// ----------------------------------------------------------------------------
`include "wildcard_nfa_matcher_unit_assert.svh"

module wnm_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wnm_pkg::result_t    push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output wnm_pkg::result_t    out_data
);

  logic             main_valid_r;
  logic             main_valid_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  wnm_pkg::result_t main_r;
  wnm_pkg::result_t main_nxt;
  wnm_pkg::result_t skid_r;
  wnm_pkg::result_t skid_nxt;
  logic             take;

  assign take = main_valid_r & ~out_stall;

  // buffer control
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (take) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  `WNM_ASSERT(a_skid_behind_main, skid_valid_r |-> main_valid_r, "skid holds an item ahead of main")
  `WNM_ASSERT(a_skid_drains, (skid_valid_r && take) |=> (main_valid_r && !skid_valid_r), "skid item not moved to main")
  `WNM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!main_valid_r && !skid_valid_r), "buffer not empty after reset")

endmodule

### design/wildcard_nfa_matcher_unit.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher unit
// Glob match of a byte stream against a configured pattern of up to 32 bytes.
// ----------------------------------------------------------------------------
// Takes one text byte per clock unless stalled and returns one result item
// per byte. A row of 32 cells holds the pattern bytes and the live position
// bits; each byte is compared in every cell at once, live tokens hop to the
// neighbor cell, and a single 33-bit carry chain spreads them through runs
// of '*'. That compare plus carry chain is the feedback loop that sets the
// clock. Results sit in a two-entry output buffer, so the input stalls only
// when two results wait. '*' (0x2A) and '?' (0x3F) in the pattern are always
// wildcards. Raise first_of_text on the first byte of each text and after any
// pattern write. cfg_ready is always high.
`include "wildcard_nfa_matcher_unit_assert.svh"

module wildcard_nfa_matcher_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // text items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wnm_pkg::BYTE_W-1:0]      in_text_byte,
  input  logic                            in_first_of_text,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_matched,
  output logic                            out_no_live_position,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wnm_pkg::WORD_W-1:0]      cfg_data
);

  localparam int NCELL = wnm_pkg::PATTERN_MAX;

  logic [wnm_pkg::LEN_W-1:0]   len_r;
  logic [wnm_pkg::LEN_W-1:0]   used_len;
  logic                        in_acc;
  logic                        cfg_we;
  logic                        word_we;
  wnm_pkg::cell_ctl_t          ctl    [NCELL];
  wnm_pkg::cell_out_t          cell_o [NCELL];
  logic [wnm_pkg::LIVE_W-1:0]  raw;
  logic [wnm_pkg::LIVE_W-1:0]  star;
  logic [wnm_pkg::LIVE_W-1:0]  closed;
  logic [wnm_pkg::LIVE_W-1:0]  seed;
  logic [NCELL-1:0]            live_vec;
  logic [NCELL-1:0]            range_vec;
  wnm_pkg::result_t            res;
  wnm_pkg::result_t            out_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign word_we   = cfg_we & (cfg_index <= wnm_pkg::CFG_PATTERN_WORD_LAST);
  assign in_acc    = in_valid & ~in_stall;

  // pattern length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we && (cfg_index == wnm_pkg::CFG_PATTERN_LENGTH)) begin
      len_r <= cfg_data[wnm_pkg::LEN_W-1:0];
    end
  end

  // lengths above the row are clipped
  assign used_len = (len_r > wnm_pkg::LEN_W'(NCELL)) ? wnm_pkg::LEN_W'(NCELL) : len_r;

  // cell row
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    always_comb begin
      ctl[i].home     = (i == 0);
      ctl[i].first    = in_first_of_text;
      ctl[i].active   = (wnm_pkg::LEN_W'(i) < used_len);
      ctl[i].in_range = (wnm_pkg::LEN_W'(i) <= used_len);
      ctl[i].load     = in_acc;
      ctl[i].wr_en    = word_we &&
                        (cfg_index[wnm_pkg::WORD_SEL_W-1:0] ==
                         wnm_pkg::WORD_SEL_W'(i / wnm_pkg::BYTES_PER_WORD));
    end

    wnm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[i]),
      .seed_bit  (seed[i]),
      .text_byte (in_text_byte),
      .wr_byte   (cfg_data[(i % wnm_pkg::BYTES_PER_WORD)*wnm_pkg::BYTE_W +: wnm_pkg::BYTE_W]),
      .live_nxt  (closed[i]),
      .cell_o    (cell_o[i])
    );

    assign star[i]      = cell_o[i].star;
    assign live_vec[i]  = cell_o[i].live;
    assign range_vec[i] = ctl[i].in_range;
  end

  // the end position is never a star
  assign star[NCELL] = 1'b0;

  // positions reached by this byte before star fill
  always_comb begin
    raw[0] = cell_o[0].stay;
    for (int i = 1; i < NCELL; i++) begin
      raw[i] = cell_o[i].stay | cell_o[i-1].adv;
    end
    raw[NCELL] = cell_o[NCELL-1].adv;
  end

  wnm_fill u_fill (
    .raw    (raw),
    .star   (star),
    .closed (closed),
    .seed   (seed)
  );

  // result of this byte
  always_comb begin
    res.matched          = closed[used_len];
    res.no_live_position = (closed == '0);
  end

  wnm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_matched          = out_data.matched;
  assign out_no_live_position = out_data.no_live_position;

  `WNM_ASSERT(a_live_within_length, (in_acc && !cfg_we) |=> ((live_vec & ~range_vec) == '0), "live bit beyond pattern length")
  `WNM_ASSERT(a_match_is_live, in_acc |-> !(res.matched && res.no_live_position), "match reported with no live position")
  `WNM_ASSERT(a_stall_needs_result, in_stall |-> out_valid, "input stalled with no result waiting")

endmodule

### dv/wnm_checker.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher checker
// Watches the config, text and result channels, tracks the live position
// vector of the glob automaton and compares every result item in order.
// ----------------------------------------------------------------------------
module wnm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [wnm_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_first_of_text,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_matched,
  input  logic                          out_no_live_position,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wnm_pkg::WORD_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked_count,
  output int                            match_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  // shadow of the pattern registers and the live positions
  logic [wnm_pkg::BYTE_W-1:0] glob_bytes [wnm_pkg::PATTERN_MAX];
  logic [wnm_pkg::LEN_W-1:0]  glob_len;
  logic [wnm_pkg::LIVE_W-1:0] live_vec;
  wnm_pkg::result_t           match_q [$];
  int                         n_fail;
  int                         n_checked;
  int                         n_match;

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    match_count   = 0;
    n_fail        = 0;
    n_checked     = 0;
    n_match       = 0;
  end

  // lengths above the maximum act as the maximum
  function automatic int clamp_len(logic [wnm_pkg::LEN_W-1:0] l);
    return (int'(l) > wnm_pkg::PATTERN_MAX) ? wnm_pkg::PATTERN_MAX : int'(l);
  endfunction

  // a live star also makes the next position live; ripples upward
  function automatic logic [wnm_pkg::LIVE_W-1:0] spread_stars(
    logic [wnm_pkg::LIVE_W-1:0] v, int n);
    for (int i = 0; i < n; i++) begin
      if (v[i] && glob_bytes[i] == wnm_pkg::STAR_CODE) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  // one text byte through the automaton
  function automatic wnm_pkg::result_t advance_glob(logic [wnm_pkg::BYTE_W-1:0] b,
                                                    logic restart);
    int                         n;
    logic [wnm_pkg::LIVE_W-1:0] keep;
    logic [wnm_pkg::LIVE_W-1:0] cur;
    logic [wnm_pkg::LIVE_W-1:0] nxt;
    wnm_pkg::result_t           r;
    n = clamp_len(glob_len);
    for (int i = 0; i < wnm_pkg::LIVE_W; i++) keep[i] = (i <= n);
    cur = restart ? spread_stars(wnm_pkg::LIVE_W'(1), n) : (live_vec & keep);
    nxt = '0;
    for (int i = 0; i < n; i++) begin
      if (cur[i]) begin
        if (glob_bytes[i] == wnm_pkg::STAR_CODE) nxt[i] = 1'b1;
        else if (glob_bytes[i] == wnm_pkg::QUEST_CODE || glob_bytes[i] == b)
          nxt[i+1] = 1'b1;
      end
    end
    nxt = spread_stars(nxt, n) & keep;
    live_vec = nxt;
    r.matched = nxt[n];
    r.no_live_position = (nxt == '0);
    return r;
  endfunction

  always @(posedge clk) begin : track_and_compare
    wnm_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < wnm_pkg::PATTERN_MAX; i++) glob_bytes[i] = '0;
      glob_len = '0;
      live_vec = wnm_pkg::LIVE_W'(1);
      match_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= wnm_pkg::CFG_PATTERN_WORD_LAST) begin
          for (int b = 0; b < wnm_pkg::BYTES_PER_WORD; b++)
            glob_bytes[int'(cfg_index) * wnm_pkg::BYTES_PER_WORD + b] =
              cfg_data[wnm_pkg::BYTE_W*b +: wnm_pkg::BYTE_W];
        end else if (cfg_index == wnm_pkg::CFG_PATTERN_LENGTH) begin
          glob_len = cfg_data[wnm_pkg::LEN_W-1:0];
        end
      end
      // accepted text item
      if (in_valid && !in_stall)
        match_q.push_back(advance_glob(in_text_byte, in_first_of_text));
      // accepted result item
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_MAX)
            $display("%0t: result item with none expected (matched=%0b no_live=%0b)",
                     $realtime, out_matched, out_no_live_position);
        end else begin
          want = match_q.pop_front();
          n_checked++;
          if (out_matched) n_match++;
          if (want.matched !== out_matched ||
              want.no_live_position !== out_no_live_position) begin
            n_fail++;
            if (n_fail <= REPORT_MAX)
              $display("%0t: result %0d expected matched=%0b no_live=%0b, got %0b %0b",
                       $realtime, n_checked, want.matched, want.no_live_position,
                       out_matched, out_no_live_position);
          end
        end
      end
    end
    fail_count    <= n_fail;
    pending       <= match_q.size();
    checked_count <= n_checked;
    match_count   <= n_match;
  end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Wildcard NFA matcher testbench
// Programs glob patterns, streams texts built from them plus noise under
// several idle and stall mixes, and lets the checker score every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [wnm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 75;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [wnm_pkg::BYTE_W-1:0]    in_text_byte = '0;
  logic                          in_first_of_text = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_matched;
  logic                          out_no_live_position;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [wnm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wnm_pkg::WORD_W-1:0]    cfg_data = '0;

  int fail_count;
  int pending;
  int checked_count;
  int match_count;

  // stimulus state
  logic [wnm_pkg::BYTE_W-1:0] glob_bytes [wnm_pkg::PATTERN_MAX];
  int                         glob_used = 0;
  int                         send_idle_pct = 0;
  int                         stall_pct = 0;
  int                         hold_cycles = 0;
  int                         items_sent = 0;
  int                         settings_used = 0;

  wildcard_nfa_matcher_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_text_byte         (in_text_byte),
    .in_first_of_text     (in_first_of_text),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched          (out_matched),
    .out_no_live_position (out_no_live_position),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  wnm_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_text_byte         (in_text_byte),
    .in_first_of_text     (in_first_of_text),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched          (out_matched),
    .out_no_live_position (out_no_live_position),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending              (pending),
    .checked_count        (checked_count),
    .match_count          (match_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // hard stop
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [wnm_pkg::BYTE_W-1:0] pick_letter();
    return wnm_pkg::BYTE_W'(8'h61 + $urandom_range(2));
  endfunction

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 88;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 88;
      end
      default: begin
        send_idle_pct = 25;
        stall_pct     = 25;
      end
    endcase
  endtask

  task automatic cfg_write(input logic [wnm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wnm_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the length write are junk on purpose
  task automatic write_length(input int len_val);
    logic [wnm_pkg::WORD_W-1:0] data;
    data = {$urandom, $urandom};
    data[wnm_pkg::LEN_W-1:0] = wnm_pkg::LEN_W'(len_val);
    cfg_write(wnm_pkg::CFG_PATTERN_LENGTH, data);
    glob_used = (len_val > wnm_pkg::PATTERN_MAX) ? wnm_pkg::PATTERN_MAX : len_val;
  endtask

  task automatic program_pattern(input int len_val);
    logic [wnm_pkg::WORD_W-1:0] data;
    for (int w = 0; w < wnm_pkg::PATTERN_WORDS; w++) begin
      for (int b = 0; b < wnm_pkg::BYTES_PER_WORD; b++)
        data[wnm_pkg::BYTE_W*b +: wnm_pkg::BYTE_W] =
          glob_bytes[w * wnm_pkg::BYTES_PER_WORD + b];
      cfg_write(wnm_pkg::CFG_IDX_W'(w), data);
    end
    write_length(len_val);
    settings_used++;
  endtask

  task automatic fill_pattern(input string s);
    for (int i = 0; i < wnm_pkg::PATTERN_MAX; i++)
      glob_bytes[i] = (i < s.len()) ? wnm_pkg::BYTE_W'(s[i]) : wnm_pkg::BYTE_W'(0);
  endtask

  task automatic random_pattern();
    int r;
    for (int i = 0; i < wnm_pkg::PATTERN_MAX; i++) begin
      r = $urandom_range(99);
      if (r < 20) glob_bytes[i] = wnm_pkg::STAR_CODE;
      else if (r < 35) glob_bytes[i] = wnm_pkg::QUEST_CODE;
      else if (r < 95) glob_bytes[i] = pick_letter();
      else glob_bytes[i] = wnm_pkg::BYTE_W'($urandom);
    end
  endtask

  task automatic send_item(input logic [wnm_pkg::BYTE_W-1:0] b, input logic f);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_text_byte     <= b;
    in_first_of_text <= f;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // drop valid and let every expected result come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // one text: mostly derived from the pattern, else noise
  task automatic send_text(input bit well_formed);
    logic [wnm_pkg::BYTE_W-1:0] txt [$];
    int                         r;
    int                         k;
    if (well_formed) begin
      for (int i = 0; i < glob_used; i++) begin
        if (glob_bytes[i] == wnm_pkg::STAR_CODE) begin
          k = $urandom_range(3);
          repeat (k) txt.push_back(pick_letter());
        end else if (glob_bytes[i] == wnm_pkg::QUEST_CODE) begin
          txt.push_back(wnm_pkg::BYTE_W'($urandom));
        end else begin
          txt.push_back(glob_bytes[i]);
        end
      end
      if (txt.size() == 0) txt.push_back(pick_letter());
      r = $urandom_range(99);
      if (r < 15) txt[$urandom_range(txt.size() - 1)] = pick_letter();
      else if (r < 25) txt.push_back(pick_letter());
      else if (r < 30 && txt.size() > 1) txt.delete(txt.size() - 1);
    end else begin
      k = $urandom_range(8, 1);
      repeat (k) txt.push_back(($urandom_range(1)) ? wnm_pkg::BYTE_W'($urandom)
                                                   : pick_letter());
    end
    foreach (txt[i]) send_item(txt[i], i == 0);
  endtask

  task automatic directed_tests();
    // registers at reset: empty pattern
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    wait_idle();
    // star and question mark mix, then a dead match that stays dead
    fill_pattern("a*?b");
    program_pattern(4);
    send_item("a", 1'b1);
    send_item("x", 1'b0);
    send_item("y", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b1);
    send_item("a", 1'b0);
    // length rewritten in the middle of a text, no restart
    send_item("a", 1'b1);
    send_item("b", 1'b0);
    wait_idle();
    write_length(2);
    send_item("z", 1'b0);
    wait_idle();
    // all stars, length above the maximum
    fill_pattern("");
    for (int i = 0; i < wnm_pkg::PATTERN_MAX; i++) glob_bytes[i] = wnm_pkg::STAR_CODE;
    program_pattern(63);
    send_item(wnm_pkg::STAR_CODE, 1'b1);
    send_item(wnm_pkg::QUEST_CODE, 1'b0);
    wait_idle();
    // all-ones pattern words
    for (int i = 0; i < wnm_pkg::PATTERN_MAX; i++) glob_bytes[i] = 8'hFF;
    program_pattern(wnm_pkg::PATTERN_MAX);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFE, 1'b0);
    wait_idle();
    // single '?'
    fill_pattern("?");
    program_pattern(1);
    send_item(8'h00, 1'b1);
    send_item(8'h01, 1'b0);
    wait_idle();
    // empty pattern over stale words, plus a write to an unmapped index
    random_pattern();
    program_pattern(0);
    cfg_write(CFG_UNMAPPED, {$urandom, $urandom});
    send_item(8'h41, 1'b1);
    wait_idle();
    // wildcard byte in the text is only a literal there
    fill_pattern("x");
    program_pattern(1);
    send_item(wnm_pkg::QUEST_CODE, 1'b1);
    wait_idle();
  endtask

  initial begin : stimulus
    int len_val;
    int start_count;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_NONE);
    directed_tests();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       len_val = wnm_pkg::PATTERN_MAX;
        6:       len_val = 63;
        9:       len_val = 1;
        10:      len_val = 40;
        default: len_val = $urandom_range(10, 1);
      endcase
      random_pattern();
      program_pattern(len_val);
      set_idle(idle_mode_t'(p % 4));
      // receiver holds off while texts keep coming, so the block backs up
      if (p == 4) hold_cycles = 300;
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS)
        send_text($urandom_range(99) < 80);
      wait_idle();
    end

    set_idle(IDLE_NONE);
    wait_idle();
    repeat (5) @(posedge clk);
    $display("Covered %0d text items over %0d pattern settings; %0d results checked, %0d matches.",
             items_sent, settings_used, checked_count, match_count);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
